### rtl/tkv_pkg.sv
// Shared constants, codes and word types of the two-value key table.
`default_nettype none

package tkv_pkg;

   localparam int DEPTH          = 16;
   localparam int IDX_W          = $clog2(DEPTH);
   localparam int CNT_W          = $clog2(DEPTH + 1);
   localparam int DATA_W         = 32;
   localparam int CAP_W          = 5;
   localparam int OUT_CNT_W      = 5;
   localparam int VALUES_PER_KEY = 2;

   localparam logic [1:0] MODE_ADD     = 2'd0;
   localparam logic [1:0] MODE_SEARCH  = 2'd1;
   localparam logic [1:0] MODE_REMOVE  = 2'd2;
   localparam logic [1:0] MODE_REPLACE = 2'd3;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic                     first_found;
      logic signed [DATA_W-1:0] first_value;
      logic                     second_found;
      logic signed [DATA_W-1:0] second_value;
      logic [OUT_CNT_W-1:0]     entry_count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef struct packed {
      logic                   rd_en;
      logic [IDX_W-1:0]       rd_addr;
      logic                   wr_en;
      logic [IDX_W-1:0]       wr_addr;
      logic [2*DATA_W-1:0]    wr_data;
   } ram_req_type;

   typedef struct packed {
      logic    idle;
      logic    done;
      rsp_type result;
   } seq_stat_type;

endpackage

`default_nettype wire

### rtl/tkv_ifs.sv
// Channel interfaces: request, response and capacity register write.
`default_nettype none

interface tkv_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         mode;
   logic signed [tkv_pkg::DATA_W-1:0]  key;
   logic signed [tkv_pkg::DATA_W-1:0]  value;
   logic signed [tkv_pkg::DATA_W-1:0]  new_value;

   modport source (output valid, mode, key, value, new_value, input ready);
   modport sink   (input valid, mode, key, value, new_value, output ready);
endinterface

interface tkv_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 ok;
   logic                                 first_found;
   logic signed [tkv_pkg::DATA_W-1:0]    first_value;
   logic                                 second_found;
   logic signed [tkv_pkg::DATA_W-1:0]    second_value;
   logic [tkv_pkg::OUT_CNT_W-1:0]        entry_count;
   logic                                 is_empty;
   logic                                 is_full;

   modport source (output valid, ok, first_found, first_value, second_found, second_value,
                   entry_count, is_empty, is_full, input ready);
   modport sink   (input valid, ok, first_found, first_value, second_found, second_value,
                   entry_count, is_empty, is_full, output ready);
endinterface

interface tkv_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tkv_pkg::CAP_W-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/two_value_key_table.sv
// Top level of the two-value key table: channels, capacity register, result word.
//
//   channel  dir  handshake      word
//   req_     in   valid/ready    mode, key, value, new_value
//   rsp_     out  valid/ready    ok, found flags and values, count, empty, full
//   csr_     in   valid/ready    capacity_in_use (always ready)
//
// An item walks the stored pairs through one memory read port, one pair a cycle,
// then an apply state appends, rewrites or starts a shift; the result word is registered.
// A remove that hits then shifts the later pairs down through the write port.
// Reset empties the table (count 0) and sets the capacity to 16; no clearing pass.
// The next item is taken while a result waits; it stalls before its final write.
`default_nettype none

module two_value_key_table (
   input  wire logic   clock,
   input  wire logic   reset,
   tkv_req_if.sink     req_chan,
   tkv_rsp_if.source   rsp_chan,
   tkv_csr_if.sink     csr_chan
);

   localparam int CNT_W = tkv_pkg::CNT_W;

   logic [tkv_pkg::CAP_W-1:0]      cap_ff, cap_in;
   logic [CNT_W-1:0]               cap_eff;
   logic                           rsp_valid_ff, rsp_valid_in;
   tkv_pkg::rsp_type               rsp_word_ff;
   tkv_pkg::req_type               req_word;
   tkv_pkg::ram_req_type           ram_req;
   tkv_pkg::seq_stat_type          stat;
   logic [2*tkv_pkg::DATA_W-1:0]   rd_data;
   logic                           start;
   logic                           res_free;

   assign csr_chan.ready = 1'b1;
   assign cap_in = (csr_chan.valid) ? csr_chan.data : cap_ff;
   assign cap_eff = (int'(cap_ff) > tkv_pkg::DEPTH) ? CNT_W'(tkv_pkg::DEPTH) : CNT_W'(cap_ff);

   assign req_chan.ready     = stat.idle;
   assign start              = req_chan.valid && stat.idle;
   assign req_word.mode      = req_chan.mode;
   assign req_word.key       = req_chan.key;
   assign req_word.value     = req_chan.value;
   assign req_word.new_value = req_chan.new_value;

   assign res_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = stat.done || (rsp_valid_ff && !rsp_chan.ready);

   tkv_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (req_word),
      .cap      (cap_eff),
      .res_free (res_free),
      .rd_data  (rd_data),
      .ram_req  (ram_req),
      .stat     (stat)
   );

   tkv_ram #(
      .WIDTH (2 * tkv_pkg::DATA_W),
      .DEPTH (tkv_pkg::DEPTH)
   ) u_pairs (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= tkv_pkg::CAP_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_word_ff <= stat.result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = rsp_word_ff.ok;
   assign rsp_chan.first_found  = rsp_word_ff.first_found;
   assign rsp_chan.first_value  = rsp_word_ff.first_value;
   assign rsp_chan.second_found = rsp_word_ff.second_found;
   assign rsp_chan.second_value = rsp_word_ff.second_value;
   assign rsp_chan.entry_count  = rsp_word_ff.entry_count;
   assign rsp_chan.is_empty     = rsp_word_ff.is_empty;
   assign rsp_chan.is_full      = rsp_word_ff.is_full;

endmodule

`default_nettype wire

### rtl/tkv_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
`default_nettype none

module tkv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/tkv_seq.sv
// Operation sequencer: walks the pair memory, then appends, rewrites, shifts or just reports.
`default_nettype none

module tkv_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire tkv_pkg::req_type              item,
   input  wire logic [tkv_pkg::CNT_W-1:0]     cap,
   input  wire logic                          res_free,
   input  wire logic [2*tkv_pkg::DATA_W-1:0]  rd_data,
   output tkv_pkg::ram_req_type               ram_req,
   output tkv_pkg::seq_stat_type              stat
);

   localparam int CNT_W  = tkv_pkg::CNT_W;
   localparam int IDX_W  = tkv_pkg::IDX_W;
   localparam int DATA_W = tkv_pkg::DATA_W;
   localparam logic [1:0] HITS_MAX = 2'(tkv_pkg::VALUES_PER_KEY);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_SHIFT = 2'd3;

   logic [1:0]              state_ff, state_in;
   tkv_pkg::req_type        item_ff, item_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    rvld_ff, rvld_in;
   logic [IDX_W-1:0]        ridx_ff, ridx_in;
   logic [1:0]              hits_ff, hits_in;
   logic signed [DATA_W-1:0] v1_ff, v1_in, v2_ff, v2_in;
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;

   logic                    issue_more;
   logic signed [DATA_W-1:0] rd_key, rd_val;
   logic                    key_eq, pair_eq;
   logic                    ok;
   logic                    done;
   logic                    is_search;

   assign rd_key     = rd_data[2*DATA_W-1:DATA_W];
   assign rd_val     = rd_data[DATA_W-1:0];
   assign key_eq     = rd_key == item_ff.key;
   assign pair_eq    = key_eq && (rd_val == item_ff.value);
   assign issue_more = issue_ff < count_ff;
   assign is_search  = item_ff.mode == tkv_pkg::MODE_SEARCH;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      count_in = count_ff;
      issue_in = issue_ff;
      rvld_in  = 1'b0;
      ridx_in  = ridx_ff;
      hits_in  = hits_ff;
      v1_in    = v1_ff;
      v2_in    = v2_ff;
      hit_in   = hit_ff;
      pos_in   = pos_ff;
      ok       = 1'b0;
      ram_req  = '0;
      done     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = item;
               issue_in = '0;
               hits_in  = '0;
               v1_in    = '0;
               v2_in    = '0;
               hit_in   = 1'b0;
               pos_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ram_req.rd_en   = issue_more;
            ram_req.rd_addr = issue_ff[IDX_W-1:0];
            rvld_in         = issue_more;
            ridx_in         = issue_ff[IDX_W-1:0];
            if (issue_more) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (rvld_ff) begin
               if (key_eq) begin
                  if (hits_ff == 2'd0) begin
                     v1_in = rd_val;
                  end else if (hits_ff == 2'd1) begin
                     v2_in = rd_val;
                  end
                  if (hits_ff != HITS_MAX) begin
                     hits_in = hits_ff + 2'd1;
                  end
               end
               // remove keeps the last match, replace the first
               if (pair_eq && (item_ff.mode == tkv_pkg::MODE_REMOVE ||
                               (item_ff.mode == tkv_pkg::MODE_REPLACE && !hit_ff))) begin
                  hit_in = 1'b1;
                  pos_in = ridx_ff;
               end
            end
            if (!issue_more && !rvld_ff) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (res_free) begin
               state_in = ST_IDLE;
               unique case (item_ff.mode)
                  tkv_pkg::MODE_ADD: begin
                     if (count_ff < cap && hits_ff < HITS_MAX) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = count_ff[IDX_W-1:0];
                        ram_req.wr_data = {item_ff.key, item_ff.value};
                        count_in        = count_ff + CNT_W'(1);
                        ok              = 1'b1;
                     end
                     done = 1'b1;
                  end
                  tkv_pkg::MODE_SEARCH: begin
                     ok   = hits_ff != 2'd0;
                     done = 1'b1;
                  end
                  tkv_pkg::MODE_REMOVE: begin
                     if (hit_ff) begin
                        issue_in = CNT_W'(pos_ff) + CNT_W'(1);
                        state_in = ST_SHIFT;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  tkv_pkg::MODE_REPLACE: begin
                     if (hit_ff) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = pos_ff;
                        ram_req.wr_data = {item_ff.key, item_ff.new_value};
                        ok              = 1'b1;
                     end
                     done = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // read one place above, write one place below on the next cycle
            ram_req.rd_en   = issue_more;
            ram_req.rd_addr = issue_ff[IDX_W-1:0];
            rvld_in         = issue_more;
            ridx_in         = issue_ff[IDX_W-1:0];
            if (issue_more) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (rvld_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = ridx_ff - IDX_W'(1);
               ram_req.wr_data = rd_data;
            end
            if (!issue_more && !rvld_ff && res_free) begin
               count_in = count_ff - CNT_W'(1);
               ok       = 1'b1;
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      stat.idle                = state_ff == ST_IDLE;
      stat.done                = done;
      stat.result.ok           = ok;
      stat.result.first_found  = is_search && (hits_ff != 2'd0);
      stat.result.first_value  = is_search ? v1_ff : '0;
      stat.result.second_found = is_search && (hits_ff == HITS_MAX);
      stat.result.second_value = (is_search && hits_ff == HITS_MAX) ? v2_ff : '0;
      stat.result.entry_count  = tkv_pkg::OUT_CNT_W'(count_in);
      stat.result.is_empty     = count_in == '0;
      stat.result.is_full      = count_in >= cap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rvld_ff  <= rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      issue_ff <= issue_in;
      ridx_ff  <= ridx_in;
      hits_ff  <= hits_in;
      v1_ff    <= v1_in;
      v2_ff    <= v2_in;
      hit_ff   <= hit_in;
      pos_ff   <= pos_in;
   end

endmodule

`default_nettype wire
